[src/lmeh_pkg.sv]
package lmeh_pkg;

  // Largest speed table the block supports; unused entries read as zero.
  localparam int unsigned TBL_MAX   = 12;
  localparam int unsigned TBL_IDX_W = 4;

  // Restoring divider: 34-bit numerator, one quotient bit per step.
  localparam int unsigned NUM_W     = 34;
  localparam int unsigned DEN_W     = 18;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned STEP_W    = 6;

  // Working value: -2 or an exposure up to 65535.
  localparam int unsigned V_W = 18;

  // APB register port.
  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  // Register indexes.
  localparam logic [2:0] REG_CMP_FAST    = 3'd0;
  localparam logic [2:0] REG_CMP_SLOW    = 3'd1;
  localparam logic [2:0] REG_OFFSET      = 3'd2;
  localparam logic [2:0] REG_LIMIT       = 3'd3;
  localparam logic [2:0] REG_THRESH      = 3'd4;
  localparam logic [2:0] REG_SPEEDS_LOW  = 3'd5;
  localparam logic [2:0] REG_SPEEDS_MID  = 3'd6;
  localparam logic [2:0] REG_SPEEDS_HIGH = 3'd7;

  localparam logic [15:0] LIMIT_RST  = 16'd44250;
  localparam logic [15:0] THRESH_RST = 16'd100;

  // Helper modes.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  // Search window margins around the table ends.
  localparam logic [18:0] BELOW_MARGIN = 19'd6;
  localparam logic [18:0] ABOVE_MARGIN = 19'd128;

  typedef struct packed {
    logic [15:0]                    cmp_fast;
    logic [15:0]                    cmp_slow;
    logic [15:0]                    offset;
    logic [15:0]                    limit;
    logic [15:0]                    thresh;
    logic [TBL_MAX-1:0][15:0]       speeds;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 mul;
    logic                 div_load;
    logic                 div_step;
    logic                 fin_e;
    logic                 srch_first;
    logic                 srch_step;
    logic [TBL_IDX_W-1:0] srch_idx;
    logic                 commit;
  } cmd_t;

  typedef struct packed {
    logic manual;
  } sts_t;

endpackage

[src/lmeh_in_if.sv]
interface lmeh_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;
  logic [15:0] pulse_count;
  logic        pulse_overflow;
  logic [3:0]  dial_slot;
  logic [1:0]  helper_mode;
  logic        fast_film;

  modport source (
    output valid, elapsed_ms, pulse_count, pulse_overflow, dial_slot, helper_mode, fast_film,
    input  ready
  );
  modport sink (
    input  valid, elapsed_ms, pulse_count, pulse_overflow, dial_slot, helper_mode, fast_film,
    output ready
  );
endinterface

[src/lmeh_out_if.sv]
interface lmeh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] predicted_exposure;
  logic        too_long;
  logic [3:0]  slot_code;
  logic        led_blue;
  logic        led_red;

  modport source (
    output valid, predicted_exposure, too_long, slot_code, led_blue, led_red,
    input  ready
  );
  modport sink (
    input  valid, predicted_exposure, too_long, slot_code, led_blue, led_red,
    output ready
  );
endinterface

[src/lmeh_regs.sv]
module lmeh_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lmeh_pkg::APB_AW-1:0] paddr,
  input  logic [lmeh_pkg::APB_DW-1:0] pwdata,
  output logic [lmeh_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output lmeh_pkg::cfg_t              cfg
);
  import lmeh_pkg::*;

  logic [15:0] cmp_fast_r;
  logic [15:0] cmp_slow_r;
  logic [15:0] offset_r;
  logic [15:0] limit_r;
  logic [15:0] thresh_r;
  logic [63:0] speeds_low_r;
  logic [63:0] speeds_mid_r;
  logic [47:0] speeds_high_r;
  logic [2:0]  idx;
  logic        aligned;
  logic        wr_en;

  assign idx     = paddr[APB_AW-1:3];
  assign aligned = (paddr[2:0] == 3'd0);
  assign wr_en   = psel && penable && pwrite && aligned;
  assign pready  = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_fast_r    <= '0;
      cmp_slow_r    <= '0;
      offset_r      <= '0;
      limit_r       <= LIMIT_RST;
      thresh_r      <= THRESH_RST;
      speeds_low_r  <= '0;
      speeds_mid_r  <= '0;
      speeds_high_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CMP_FAST:    cmp_fast_r    <= pwdata[15:0];
        REG_CMP_SLOW:    cmp_slow_r    <= pwdata[15:0];
        REG_OFFSET:      offset_r      <= pwdata[15:0];
        REG_LIMIT:       limit_r       <= pwdata[15:0];
        REG_THRESH:      thresh_r      <= pwdata[15:0];
        REG_SPEEDS_LOW:  speeds_low_r  <= pwdata;
        REG_SPEEDS_MID:  speeds_mid_r  <= pwdata;
        REG_SPEEDS_HIGH: speeds_high_r <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read data is a plain decode of the address.
  always_comb begin
    prdata = '0;
    if (aligned) begin
      case (idx)
        REG_CMP_FAST:    prdata = {48'd0, cmp_fast_r};
        REG_CMP_SLOW:    prdata = {48'd0, cmp_slow_r};
        REG_OFFSET:      prdata = {48'd0, offset_r};
        REG_LIMIT:       prdata = {48'd0, limit_r};
        REG_THRESH:      prdata = {48'd0, thresh_r};
        REG_SPEEDS_LOW:  prdata = speeds_low_r;
        REG_SPEEDS_MID:  prdata = speeds_mid_r;
        REG_SPEEDS_HIGH: prdata = {16'd0, speeds_high_r};
        default:         prdata = '0;
      endcase
    end
  end

  // The speed table is the three words laid end to end, with a zero entry on top.
  always_comb begin
    cfg.cmp_fast = cmp_fast_r;
    cfg.cmp_slow = cmp_slow_r;
    cfg.offset   = offset_r;
    cfg.limit    = limit_r;
    cfg.thresh   = thresh_r;
    cfg.speeds   = {16'd0, speeds_high_r, speeds_mid_r, speeds_low_r};
  end

endmodule

[src/lmeh_ctrl.sv]
module lmeh_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lmeh_pkg::sts_t sts,
  output lmeh_pkg::cmd_t cmd
);
  import lmeh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_SUM,
    S_SRCH,
    S_FIN
  } state_t;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] SRCH_LAST = STEP_W'(TABLE_ENTRIES - 1);

  state_t            state_r;
  state_t            state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing of one word through capture, multiply, divide, sum, search (manual mode only) and commit.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.srch_idx  = step_r[TBL_IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.fin_e = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.manual ? S_SRCH : S_FIN;
      end
      S_SRCH: begin
        cmd.srch_first = (step_r == '0);
        cmd.srch_step  = (step_r != '0);
        step_nxt       = step_r + 1'b1;
        if (step_r == SRCH_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/lmeh_dp.sv]
module lmeh_dp #(
  parameter int unsigned TABLE_ENTRIES = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lmeh_pkg::cfg_t cfg,
  input  lmeh_pkg::cmd_t cmd,
  output lmeh_pkg::sts_t sts,
  input  logic [15:0]    elapsed_ms,
  input  logic [15:0]    pulse_count,
  input  logic           pulse_overflow,
  input  logic [3:0]     dial_slot,
  input  logic [1:0]     helper_mode,
  input  logic           fast_film,
  output logic [15:0]    predicted_exposure,
  output logic           too_long,
  output logic [3:0]     slot_code,
  output logic           led_blue,
  output logic           led_red
);
  import lmeh_pkg::*;

  localparam logic [3:0] CODE_ABOVE = 4'(TABLE_ENTRIES);
  localparam logic [3:0] CODE_BELOW = 4'(TABLE_ENTRIES + 1);

  // Captured word.
  logic [15:0] ms_r;
  logic [16:0] count_r;
  logic [3:0]  dial_r;
  logic [1:0]  mode_r;
  logic        fast_r;

  // Arithmetic.
  logic [31:0]      prod_r;
  logic [NUM_W-1:0] num_r;
  logic [REM_W-1:0] rem_r;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] shifted;
  logic [DEN_W:0]   trial;
  logic [NUM_W:0]   e_sum;
  logic [15:0]      shown_r;
  logic             too_long_r;
  logic [V_W-1:0]   v_r;

  // Search.
  logic [15:0]          entry;
  logic [18:0]          diff;
  logic [18:0]          diff_neg;
  logic [V_W-1:0]       delta;
  logic [V_W-1:0]       best_d_r;
  logic [TBL_IDX_W-1:0] best_idx_r;

  // Result and LED state.
  logic [15:0] pe_r;
  logic        tl_r;
  logic [3:0]  code_r;
  logic        blue_r;
  logic        red_r;
  logic [3:0]  code_nxt;
  logic        blue_nxt;
  logic        red_nxt;
  logic        below;
  logic        above;
  logic        auto_on;
  logic [18:0] v_ext;

  assign sts.manual = (mode_r == MODE_MANUAL);

  // The rounding divisor is twice the count.
  assign den     = {count_r, 1'b0};
  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {1'b0, den};
  assign e_sum   = {1'b0, num_r} + {{(NUM_W-15){1'b0}}, cfg.offset};

  // Capture, multiply, divide and add the offset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ms_r    <= elapsed_ms;
      count_r <= pulse_overflow ? 17'h10000 : {1'b0, pulse_count};
      dial_r  <= dial_slot;
      mode_r  <= helper_mode;
      fast_r  <= fast_film;
    end
    if (cmd.mul) begin
      prod_r <= ms_r * (fast_r ? cfg.cmp_fast : cfg.cmp_slow);
    end
    if (cmd.div_load) begin
      num_r <= {1'b0, prod_r, 1'b0} + {{(NUM_W-17){1'b0}}, count_r};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], ~trial[DEN_W]};
      if (!trial[DEN_W]) begin
        rem_r <= trial[REM_W-1:0];
      end else begin
        rem_r <= shifted[REM_W-1:0];
      end
    end
    if (cmd.fin_e) begin
      if (count_r == '0) begin
        shown_r    <= 16'hFFFF;
        too_long_r <= 1'b1;
        v_r        <= -V_W'(2);
      end else begin
        shown_r    <= (e_sum[NUM_W:16] != '0) ? 16'hFFFF : e_sum[15:0];
        too_long_r <= (e_sum > {{(NUM_W-15){1'b0}}, cfg.limit});
        v_r        <= (e_sum > {{(NUM_W-15){1'b0}}, cfg.limit}) ? -V_W'(2)
                                                                 : {2'b00, e_sum[15:0]};
      end
    end
  end

  // Distance from the working value to one table entry.
  assign entry    = cfg.speeds[cmd.srch_idx];
  assign v_ext    = {v_r[V_W-1], v_r};
  assign diff     = {3'b000, entry} - v_ext;
  assign diff_neg = v_ext - {3'b000, entry};
  assign delta    = diff[18] ? diff_neg[V_W-1:0] : diff[V_W-1:0];

  // Nearest entry, first one wins a tie.
  always_ff @(posedge clk) begin
    if (cmd.srch_first) begin
      best_d_r   <= delta;
      best_idx_r <= '0;
    end else if (cmd.srch_step && (delta < best_d_r)) begin
      best_d_r   <= delta;
      best_idx_r <= cmd.srch_idx;
    end
  end

  // Range checks against the table ends and the auto threshold.
  assign below   = $signed(v_ext) < ($signed({3'b000, cfg.speeds[0]}) - $signed(BELOW_MARGIN));
  assign above   = $signed(v_ext) >
                   ($signed({3'b000, cfg.speeds[TABLE_ENTRIES-1]}) + $signed(ABOVE_MARGIN));
  assign auto_on = $signed(v_ext) > $signed({3'b000, cfg.thresh});

  // Slot code and LED levels for the finished word.
  always_comb begin
    code_nxt = '0;
    blue_nxt = blue_r;
    red_nxt  = red_r;
    case (mode_r)
      MODE_OFF: begin
        blue_nxt = 1'b0;
        red_nxt  = 1'b0;
      end
      MODE_AUTO: begin
        blue_nxt = auto_on;
        red_nxt  = auto_on;
      end
      MODE_MANUAL: begin
        if (below) begin
          code_nxt = CODE_BELOW;
          red_nxt  = !red_r;
          blue_nxt = 1'b0;
        end else if (above) begin
          code_nxt = CODE_ABOVE;
          red_nxt  = 1'b0;
          blue_nxt = !blue_r;
        end else begin
          code_nxt = best_idx_r;
          blue_nxt = (dial_r < best_idx_r);
          red_nxt  = (dial_r > best_idx_r);
        end
      end
      default: ;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pe_r   <= shown_r;
      tl_r   <= too_long_r;
      code_r <= code_nxt;
    end
  end

  // LED levels are the block's only lasting state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_r <= 1'b0;
      red_r  <= 1'b0;
    end else if (cmd.commit) begin
      blue_r <= blue_nxt;
      red_r  <= red_nxt;
    end
  end

  assign predicted_exposure = pe_r;
  assign too_long           = tl_r;
  assign slot_code          = code_r;
  assign led_blue           = blue_r;
  assign led_red            = red_r;

endmodule

[src/light_meter_exposure_helper_top.sv]
// Channel   Direction  Handshake              Contents
// in_ch     sink       valid/ready            one finished sensor window word
// out_ch    source     valid/ready            exposure, flag, slot code, LED levels
// cfg_*     APB slave  psel/penable, pready=1 eight registers at byte address 8*i
//
// A word is captured, multiplied, run through the 34-step restoring divider and offset;
// in manual mode only, a table search then checks one entry per cycle. A new word is
// accepted in the cycle after the previous result is loaded into the output register,
// even while that result still waits for out_ch.ready. Reset is synchronous and active
// low; it restores the register defaults and turns both LEDs off.
module light_meter_exposure_helper_top #(
  parameter int unsigned TABLE_ENTRIES = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lmeh_in_if.sink                     in_ch,
  lmeh_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lmeh_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [lmeh_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [lmeh_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import lmeh_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers.
  lmeh_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Sequencer.
  lmeh_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, search and LED state.
  lmeh_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .elapsed_ms         (in_ch.elapsed_ms),
    .pulse_count        (in_ch.pulse_count),
    .pulse_overflow     (in_ch.pulse_overflow),
    .dial_slot          (in_ch.dial_slot),
    .helper_mode        (in_ch.helper_mode),
    .fast_film          (in_ch.fast_film),
    .predicted_exposure (out_ch.predicted_exposure),
    .too_long           (out_ch.too_long),
    .slot_code          (out_ch.slot_code),
    .led_blue           (out_ch.led_blue),
    .led_red            (out_ch.led_red)
  );

endmodule
